### src/rusc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial undistortion source coordinate: shared definitions
// Payload and configuration types, register indexes, fixed-point constants
// and the width functions that every stage derives its sizes from.
// ----------------------------------------------------------------------------
package rusc_pkg;

	// Widths of the fields on the ports.
	localparam int unsigned FIELD_BITS     = 12;
	localparam int unsigned CTR_BITS       = 16;
	localparam int unsigned K_BITS         = 32;
	localparam int unsigned SIZE_BITS      = 13;
	localparam int unsigned OUT_BITS       = 16;
	localparam int unsigned CFG_INDEX_BITS = 3;
	localparam int unsigned CFG_DATA_BITS  = 32;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_X     = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_Y     = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIAL_K1    = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIAL_K2    = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 3'd5;

	// Reset value of the image size registers.
	localparam logic [SIZE_BITS-1:0] SIZE_RESET = 13'd4096;

	// Fixed-point scaling: the factor holds one as 2^40, the k1 term drops
	// 16 bits, the k2 term drops 48 bits, and the final coordinate drops 44.
	localparam int unsigned UNITY_SHIFT  = 40;
	localparam int unsigned T1_SHIFT     = 16;
	localparam int unsigned T2_SHIFT     = 48;
	localparam int unsigned RESULT_SHIFT = 44;

	typedef struct packed {
		logic [FIELD_BITS-1:0] out_col;
		logic [FIELD_BITS-1:0] out_row;
	} pix_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] src_col;
		logic signed [OUT_BITS-1:0] src_row;
		logic                       in_bounds;
	} coord_t;

	// Configuration as the datapath sees it: coefficients kept as
	// magnitude and sign.
	typedef struct packed {
		logic [CTR_BITS-1:0]  center_x;
		logic [CTR_BITS-1:0]  center_y;
		logic [K_BITS-1:0]    k1_mag;
		logic                 k1_neg;
		logic [K_BITS-1:0]    k2_mag;
		logic                 k2_neg;
		logic [SIZE_BITS-1:0] image_width;
		logic [SIZE_BITS-1:0] image_height;
	} cfg_t;

	function automatic int unsigned max2(input int unsigned a, input int unsigned b);
		return (a > b) ? a : b;
	endfunction

	// Magnitude of a position offset in 1/16 pixel.
	function automatic int unsigned dmag_bits(input int unsigned cb);
		return max2(cb + 4, CTR_BITS);
	endfunction

	// Squared radius, sum of two squares.
	function automatic int unsigned r_bits(input int unsigned cb);
		return 2 * dmag_bits(cb) + 1;
	endfunction

	function automatic int unsigned t1_bits(input int unsigned cb);
		return K_BITS + r_bits(cb) - T1_SHIFT;
	endfunction

	function automatic int unsigned t2_bits(input int unsigned cb);
		return 2 * r_bits(cb) + K_BITS - T2_SHIFT;
	endfunction

	// Signed width of the radial factor.
	function automatic int unsigned c_bits(input int unsigned cb);
		return max2(max2(t1_bits(cb), t2_bits(cb)), UNITY_SHIFT + 1) + 2;
	endfunction

	// Signed width of the unshifted coordinate.
	function automatic int unsigned v_bits(input int unsigned cb);
		return c_bits(cb) + dmag_bits(cb) + 2;
	endfunction

	// Signed width of the integer coordinate before saturation.
	function automatic int unsigned q_bits(input int unsigned cb);
		return v_bits(cb) - RESULT_SHIFT;
	endfunction

endpackage

### src/rusc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial undistortion configuration registers
// Holds the six registers; the coefficients are stored as magnitude and
// sign so that the datapath multiplies unsigned values.
// ----------------------------------------------------------------------------
module rusc_cfg (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [rusc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [rusc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	output rusc_pkg::cfg_t                         cfg
);

	rusc_pkg::cfg_t                      cfg_q;
	logic                                wr_en;
	logic [rusc_pkg::K_BITS-1:0]         k_mag;

	// The register file takes a write in every cycle.
	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid & cfg_ready;

	// Magnitude of a two's complement coefficient; the most negative value
	// maps onto 2^31, which still fits the unsigned field.
	assign k_mag = cfg_data[rusc_pkg::K_BITS-1] ?
		(~cfg_data[rusc_pkg::K_BITS-1:0] + rusc_pkg::K_BITS'(1)) :
		cfg_data[rusc_pkg::K_BITS-1:0];

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x     <= '0;
			cfg_q.center_y     <= '0;
			cfg_q.k1_mag       <= '0;
			cfg_q.k1_neg       <= 1'b0;
			cfg_q.k2_mag       <= '0;
			cfg_q.k2_neg       <= 1'b0;
			cfg_q.image_width  <= rusc_pkg::SIZE_RESET;
			cfg_q.image_height <= rusc_pkg::SIZE_RESET;
		end else if (wr_en) begin
			unique case (cfg_index)
				rusc_pkg::CFG_CENTER_X: begin
					cfg_q.center_x <= cfg_data[rusc_pkg::CTR_BITS-1:0];
				end
				rusc_pkg::CFG_CENTER_Y: begin
					cfg_q.center_y <= cfg_data[rusc_pkg::CTR_BITS-1:0];
				end
				rusc_pkg::CFG_RADIAL_K1: begin
					cfg_q.k1_mag <= k_mag;
					cfg_q.k1_neg <= cfg_data[rusc_pkg::K_BITS-1];
				end
				rusc_pkg::CFG_RADIAL_K2: begin
					cfg_q.k2_mag <= k_mag;
					cfg_q.k2_neg <= cfg_data[rusc_pkg::K_BITS-1];
				end
				rusc_pkg::CFG_IMAGE_WIDTH: begin
					cfg_q.image_width <= cfg_data[rusc_pkg::SIZE_BITS-1:0];
				end
				rusc_pkg::CFG_IMAGE_HEIGHT: begin
					cfg_q.image_height <= cfg_data[rusc_pkg::SIZE_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/rusc_radial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial undistortion factor pipeline
// Stages one to nine: offsets from the principal point, squared radius,
// both coefficient terms from split products, and the factor magnitude.
// ----------------------------------------------------------------------------
module rusc_radial #(
	parameter int unsigned COORD_BITS = 12
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         advance,
	input  logic                                         pix_valid,
	input  rusc_pkg::pix_t                               pix,
	input  rusc_pkg::cfg_t                               cfg,
	output logic                                         vld,
	output logic [rusc_pkg::c_bits(COORD_BITS)-1:0]      c_mag,
	output logic                                         c_neg,
	output logic [2*(rusc_pkg::dmag_bits(COORD_BITS)+1)-1:0] d
);

	localparam int unsigned MW    = rusc_pkg::max2(rusc_pkg::FIELD_BITS, COORD_BITS);
	localparam int unsigned PW    = COORD_BITS + 4;
	localparam int unsigned DMW   = rusc_pkg::dmag_bits(COORD_BITS);
	localparam int unsigned DSW   = DMW + 1;
	localparam int unsigned DB    = 2 * DSW;
	localparam int unsigned RW    = rusc_pkg::r_bits(COORD_BITS);
	localparam int unsigned RLW   = (RW + 1) / 2;
	localparam int unsigned RHW   = RW - RLW;
	localparam int unsigned KW    = rusc_pkg::K_BITS;
	localparam int unsigned T1PW  = KW + RW;
	localparam int unsigned T1W   = rusc_pkg::t1_bits(COORD_BITS);
	localparam int unsigned R2W   = 2 * RW;
	localparam int unsigned P3W   = (R2W + 2) / 3;
	localparam int unsigned P3H   = R2W - 2 * P3W;
	localparam int unsigned T2PW  = R2W + KW;
	localparam int unsigned T2W   = rusc_pkg::t2_bits(COORD_BITS);
	localparam int unsigned CW    = rusc_pkg::c_bits(COORD_BITS);

	// Stage one: offsets in 1/16 pixel, split into magnitude and sign.
	logic [MW-1:0]   col_w, row_w;
	logic [PW-1:0]   col16, row16;
	logic [DSW-1:0]  du_diff, dv_diff;
	logic [DMW-1:0]  du_mag, dv_mag;

	assign col_w   = MW'(pix.out_col);
	assign row_w   = MW'(pix.out_row);
	assign col16   = {col_w[COORD_BITS-1:0], 4'b0000};
	assign row16   = {row_w[COORD_BITS-1:0], 4'b0000};
	assign du_diff = DSW'(col16) - DSW'(cfg.center_x);
	assign dv_diff = DSW'(row16) - DSW'(cfg.center_y);
	assign du_mag  = du_diff[DSW-1] ? DMW'(~du_diff + DSW'(1)) : du_diff[DMW-1:0];
	assign dv_mag  = dv_diff[DSW-1] ? DMW'(~dv_diff + DSW'(1)) : dv_diff[DMW-1:0];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic [DB-1:0] d_s1, d_s2, d_s3, d_s4, d_s5, d_s6, d_s7, d_s8, d_s9;

	// Valid bits travel beside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= pix_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// The offsets ride along until the scaling stages need them.
	always_ff @(posedge clk) begin
		if (advance) begin
			d_s1 <= {dv_diff[DSW-1], dv_mag, du_diff[DSW-1], du_mag};
			d_s2 <= d_s1;
			d_s3 <= d_s2;
			d_s4 <= d_s3;
			d_s5 <= d_s4;
			d_s6 <= d_s5;
			d_s7 <= d_s6;
			d_s8 <= d_s7;
			d_s9 <= d_s8;
		end
	end

	// Stage two: squares of the offset magnitudes.
	logic [2*DMW-1:0] usq_s2, vsq_s2;

	always_ff @(posedge clk) begin
		if (advance) begin
			usq_s2 <= d_s1[DMW-1:0] * d_s1[DMW-1:0];
			vsq_s2 <= d_s1[DSW+DMW-1:DSW] * d_s1[DSW+DMW-1:DSW];
		end
	end

	// Stage three: squared radius.
	logic [RW-1:0] r_s3;

	always_ff @(posedge clk) begin
		if (advance) begin
			r_s3 <= RW'(usq_s2) + RW'(vsq_s2);
		end
	end

	// Stage four: k1 times the radius in two halves, and the square of the
	// radius as three partial products.
	logic [KW+RLW-1:0]  k1lo_s4;
	logic [KW+RHW-1:0]  k1hi_s4;
	logic [2*RLW-1:0]   rll_s4;
	logic [RLW+RHW-1:0] rlh_s4;
	logic [2*RHW-1:0]   rhh_s4;

	always_ff @(posedge clk) begin
		if (advance) begin
			k1lo_s4 <= cfg.k1_mag * r_s3[RLW-1:0];
			k1hi_s4 <= cfg.k1_mag * r_s3[RW-1:RLW];
			rll_s4  <= r_s3[RLW-1:0] * r_s3[RLW-1:0];
			rlh_s4  <= r_s3[RLW-1:0] * r_s3[RW-1:RLW];
			rhh_s4  <= r_s3[RW-1:RLW] * r_s3[RW-1:RLW];
		end
	end

	// Stage five: join the partial products; the k1 term drops its
	// fraction bits here.
	logic [T1PW-1:0] t1_full;
	logic [R2W-1:0]  rsq_full;
	logic [T1W-1:0]  t1_s5, t1_s6, t1_s7;
	logic [R2W-1:0]  rsq_s5;

	assign t1_full  = (T1PW'(k1hi_s4) << RLW) + T1PW'(k1lo_s4);
	assign rsq_full = (R2W'(rhh_s4) << (2 * RLW)) + (R2W'(rlh_s4) << (RLW + 1)) +
		R2W'(rll_s4);

	always_ff @(posedge clk) begin
		if (advance) begin
			t1_s5  <= t1_full[T1PW-1:rusc_pkg::T1_SHIFT];
			rsq_s5 <= rsq_full;
		end
	end

	// Stage six: k2 times the radius to the fourth, in three slices.
	logic [KW+P3W-1:0] k2p0_s6, k2p1_s6;
	logic [KW+P3H-1:0] k2p2_s6;

	always_ff @(posedge clk) begin
		if (advance) begin
			k2p0_s6 <= cfg.k2_mag * rsq_s5[P3W-1:0];
			k2p1_s6 <= cfg.k2_mag * rsq_s5[2*P3W-1:P3W];
			k2p2_s6 <= cfg.k2_mag * rsq_s5[R2W-1:2*P3W];
			t1_s6   <= t1_s5;
		end
	end

	// Stage seven: join the slices and drop the fraction bits of the k2 term.
	logic [T2PW-1:0] t2_full;
	logic [T2W-1:0]  t2_s7;

	assign t2_full = (T2PW'(k2p2_s6) << (2 * P3W)) + (T2PW'(k2p1_s6) << P3W) +
		T2PW'(k2p0_s6);

	always_ff @(posedge clk) begin
		if (advance) begin
			t2_s7 <= t2_full[T2PW-1:rusc_pkg::T2_SHIFT];
			t1_s7 <= t1_s6;
		end
	end

	// Stage eight: factor = one + signed k1 term + signed k2 term, with the
	// negations folded into the adder as invert and carry in.
	logic [CW-1:0] t1_x, t2_x, c_next;
	logic [CW-1:0] c_s8;

	assign t1_x   = CW'(t1_s7);
	assign t2_x   = CW'(t2_s7);
	assign c_next = (CW'(1) << rusc_pkg::UNITY_SHIFT) +
		(cfg.k1_neg ? ~t1_x : t1_x) + CW'(cfg.k1_neg) +
		(cfg.k2_neg ? ~t2_x : t2_x) + CW'(cfg.k2_neg);

	always_ff @(posedge clk) begin
		if (advance) begin
			c_s8 <= c_next;
		end
	end

	// Stage nine: magnitude and sign of the factor.
	logic [CW-1:0] c_mag_s9;
	logic          c_neg_s9;

	always_ff @(posedge clk) begin
		if (advance) begin
			c_mag_s9 <= c_s8[CW-1] ? (~c_s8 + CW'(1)) : c_s8;
			c_neg_s9 <= c_s8[CW-1];
		end
	end

	assign vld   = vld_s9;
	assign c_mag = c_mag_s9;
	assign c_neg = c_neg_s9;
	assign d     = d_s9;

endmodule

### src/rusc_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial undistortion axis scaling
// Stages ten to thirteen for both axes side by side: factor times offset,
// principal point added back, truncation toward zero to whole pixels.
// ----------------------------------------------------------------------------
module rusc_scale #(
	parameter int unsigned COORD_BITS = 12
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             advance,
	input  logic                                             vld_in,
	input  logic [rusc_pkg::c_bits(COORD_BITS)-1:0]          c_mag,
	input  logic                                             c_neg,
	input  logic [2*(rusc_pkg::dmag_bits(COORD_BITS)+1)-1:0] d,
	input  rusc_pkg::cfg_t                                   cfg,
	output logic                                             vld,
	output logic [1:0][rusc_pkg::q_bits(COORD_BITS)-1:0]     q
);

	localparam int unsigned DMW = rusc_pkg::dmag_bits(COORD_BITS);
	localparam int unsigned DSW = DMW + 1;
	localparam int unsigned CW  = rusc_pkg::c_bits(COORD_BITS);
	localparam int unsigned CLW = (CW + 1) / 2;
	localparam int unsigned CHW = CW - CLW;
	localparam int unsigned PPW = CW + DMW;
	localparam int unsigned VW  = rusc_pkg::v_bits(COORD_BITS);
	localparam int unsigned QW  = rusc_pkg::q_bits(COORD_BITS);
	localparam int unsigned RS  = rusc_pkg::RESULT_SHIFT;

	// Lane zero is the column, lane one the row.
	logic [1:0][DMW-1:0]                d_mag;
	logic [1:0]                         d_neg;
	logic [1:0][rusc_pkg::CTR_BITS-1:0] ctr;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			d_mag[l] = d[l*DSW +: DMW];
			d_neg[l] = d[l*DSW + DMW];
		end
		ctr[0] = cfg.center_x;
		ctr[1] = cfg.center_y;
	end

	logic vld_s10, vld_s11, vld_s12, vld_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else if (advance) begin
			vld_s10 <= vld_in;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	// Stage ten: the factor magnitude in two halves times each offset.
	logic [1:0][CLW+DMW-1:0] plo_s10;
	logic [1:0][CHW+DMW-1:0] phi_s10;
	logic [1:0]              neg_s10;

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int l = 0; l < 2; l++) begin
				plo_s10[l] <= c_mag[CLW-1:0] * d_mag[l];
				phi_s10[l] <= c_mag[CW-1:CLW] * d_mag[l];
				neg_s10[l] <= c_neg ^ d_neg[l];
			end
		end
	end

	// Stage eleven: join the halves into the product magnitude.
	logic [1:0][PPW-1:0] p_s11;
	logic [1:0]          neg_s11;

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int l = 0; l < 2; l++) begin
				p_s11[l]   <= (PPW'(phi_s10[l]) << CLW) + PPW'(plo_s10[l]);
				neg_s11[l] <= neg_s10[l];
			end
		end
	end

	// Stage twelve: apply the sign and add the principal point in 2^-44.
	logic [1:0][VW-1:0] p_x;
	logic [1:0][VW-1:0] v_s12;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			p_x[l] = VW'(p_s11[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int l = 0; l < 2; l++) begin
				v_s12[l] <= (neg_s11[l] ? ~p_x[l] : p_x[l]) + VW'(neg_s11[l]) +
					(VW'(ctr[l]) << rusc_pkg::UNITY_SHIFT);
			end
		end
	end

	// Stage thirteen: drop the fraction, rounding negative values up so the
	// result truncates toward zero.
	logic [1:0][QW-1:0] q_s13;

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int l = 0; l < 2; l++) begin
				q_s13[l] <= v_s12[l][VW-1:RS] +
					QW'(v_s12[l][VW-1] & (|v_s12[l][RS-1:0]));
			end
		end
	end

	assign vld = vld_s13;
	assign q   = q_s13;

endmodule

### src/rusc_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial undistortion output stage
// Saturates both coordinates, checks them against the image size, and holds
// the result in an output register backed by one skid entry.
// ----------------------------------------------------------------------------
module rusc_out #(
	parameter int unsigned QW = 26
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld,
	input  logic [1:0][QW-1:0]    q,
	input  rusc_pkg::cfg_t        cfg,
	output logic                  advance,
	output logic                  coord_valid,
	input  logic                  coord_stall,
	output rusc_pkg::coord_t      coord
);

	localparam int unsigned OW = rusc_pkg::OUT_BITS;
	localparam logic [QW-1:0] SAT_HI = {{(QW-OW+1){1'b0}}, {(OW-1){1'b1}}};
	localparam logic [QW-1:0] SAT_LO = {{(QW-OW+1){1'b1}}, {(OW-1){1'b0}}};

	logic [1:0][OW-1:0]  sat;
	logic [1:0]          in_img;
	logic [1:0][OW-1:0]  limit;
	rusc_pkg::coord_t    res;

	// Saturation and the per-axis bounds test.
	always_comb begin
		limit[0] = OW'(cfg.image_width);
		limit[1] = OW'(cfg.image_height);
		for (int l = 0; l < 2; l++) begin
			if ($signed(q[l]) > $signed(SAT_HI)) begin
				sat[l] = SAT_HI[OW-1:0];
			end else if ($signed(q[l]) < $signed(SAT_LO)) begin
				sat[l] = SAT_LO[OW-1:0];
			end else begin
				sat[l] = q[l][OW-1:0];
			end
			in_img[l] = !sat[l][OW-1] && (sat[l] < limit[l]);
		end
		res.src_col   = sat[0];
		res.src_row   = sat[1];
		res.in_bounds = in_img[0] & in_img[1];
	end

	rusc_pkg::coord_t out_q, skid_q;
	logic             out_vld_q, skid_vld_q;
	logic             take;

	// The pipeline moves whenever the skid entry is free.
	assign advance = ~skid_vld_q;
	assign take    = out_vld_q & ~coord_stall;

	// Occupancy of the output register and the skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_q || take) begin
				out_vld_q <= skid_vld_q | (advance & vld);
			end
			if (skid_vld_q) begin
				if (take) begin
					skid_vld_q <= 1'b0;
				end
			end else if (advance && vld && out_vld_q && !take) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	// Result payloads; the skid entry drains first.
	always_ff @(posedge clk) begin
		if (!out_vld_q || take) begin
			out_q <= skid_vld_q ? skid_q : res;
		end
		if (!skid_vld_q) begin
			skid_q <= res;
		end
	end

	assign coord_valid = out_vld_q;
	assign coord       = out_q;

endmodule

### src/radial_undistort_source_coord.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial undistortion source coordinate generator
// Maps each output pixel to the source pixel under the two-coefficient
// radial lens model, with saturation and an inside-the-image flag.
//
//   Channel  Direction  Handshake              Payload
//   pix      in         pix_valid / pix_stall  rusc_pkg::pix_t (out_col, out_row)
//   coord    out        coord_valid / coord_stall
//                                              rusc_pkg::coord_t
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One coordinate is taken in every cycle in which pix_stall is low. The first
// of the thirteen arithmetic stages loads at the transfer edge, and the result
// moves through the later stages into the output register, where it is offered.
// The multipliers are split into partial products so that each stage holds
// at most one multiply or one wide add.
// Reset clears the valid bits and loads the register reset values.
// A stalled result sits in the output register while one more result drops
// into the skid entry; pix_stall rises only once that entry is occupied.
// ----------------------------------------------------------------------------
module radial_undistort_source_coord #(
	parameter int unsigned COORD_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rusc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [rusc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                pix_valid,
	output logic                                pix_stall,
	input  rusc_pkg::pix_t                      pix,
	output logic                                coord_valid,
	input  logic                                coord_stall,
	output rusc_pkg::coord_t                    coord
);

	localparam int unsigned DB = 2 * (rusc_pkg::dmag_bits(COORD_BITS) + 1);
	localparam int unsigned CW = rusc_pkg::c_bits(COORD_BITS);
	localparam int unsigned QW = rusc_pkg::q_bits(COORD_BITS);

	rusc_pkg::cfg_t     cfg;
	logic               advance;
	logic               rad_vld;
	logic [CW-1:0]      c_mag;
	logic               c_neg;
	logic [DB-1:0]      d;
	logic               scl_vld;
	logic [1:0][QW-1:0] q;

	// Items enter whenever the pipeline moves.
	assign pix_stall = ~advance;

	rusc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rusc_radial #(
		.COORD_BITS (COORD_BITS)
	) u_radial (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.pix_valid (pix_valid),
		.pix       (pix),
		.cfg       (cfg),
		.vld       (rad_vld),
		.c_mag     (c_mag),
		.c_neg     (c_neg),
		.d         (d)
	);

	rusc_scale #(
		.COORD_BITS (COORD_BITS)
	) u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.vld_in  (rad_vld),
		.c_mag   (c_mag),
		.c_neg   (c_neg),
		.d       (d),
		.cfg     (cfg),
		.vld     (scl_vld),
		.q       (q)
	);

	rusc_out #(
		.QW (QW)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.vld         (scl_vld),
		.q           (q),
		.cfg         (cfg),
		.advance     (advance),
		.coord_valid (coord_valid),
		.coord_stall (coord_stall),
		.coord       (coord)
	);

endmodule
